// ===== sv/vfdu_pkg.sv =====
// Shared types and constants for the vsync field duration updater.
// Used by the top level and by the iterative divider; depends on nothing.
package vfdu_pkg;

   localparam int WORD_W = 32;
   localparam int CLK_W  = 17;  // wide enough for the 90 kHz tick count

   // Result status codes.
   localparam logic [2:0] ST_UNCHANGED = 3'd0;
   localparam logic [2:0] ST_UPDATED   = 3'd1;
   localparam logic [2:0] ST_FIXED     = 3'd2;
   localparam logic [2:0] ST_ZERO_RATE = 3'd3;
   localparam logic [2:0] ST_BAD_CHAN  = 3'd4;
   localparam logic [2:0] ST_BAD_DEST  = 3'd5;

   localparam logic [WORD_W-1:0] PERIOD_MAX   = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] PERIOD_RESET = 32'h0FFF_FFFF;
   localparam logic [WORD_W-1:0] MIN_FIELD    = 32'd1499;

   // Reciprocals for division by a constant: q = (x * R) >> S.
   localparam logic [WORD_W-1:0] RECIP_2  = 32'h8000_0000;
   localparam logic [WORD_W-1:0] RECIP_3  = 32'hAAAA_AAAB;
   localparam logic [WORD_W-1:0] RECIP_5  = 32'hCCCC_CCCD;
   localparam logic [WORD_W-1:0] RECIP_10 = 32'hCCCC_CCCD;
   localparam int SHIFT_2  = 32;
   localparam int SHIFT_3  = 33;
   localparam int SHIFT_5  = 34;
   localparam int SHIFT_10 = 35;

   typedef struct packed {
      logic [1:0]        channel;
      logic [1:0]        destination;
      logic [WORD_W-1:0] rate_residual;
      logic [WORD_W-1:0] rate_divider;
      logic              interlaced;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [WORD_W-1:0] frame_period;
      logic [WORD_W-1:0] field_period;
   } rsp_type;

endpackage

// ===== sv/vsync_field_duration_updater.sv =====
// Vsync field duration updater: frame and field period from a rate request.
// Depends on vfdu_pkg and instantiates vfdu_div.
// A rejected or unchanged request goes from the check straight to the output state.
// A request that needs the period worked out goes through the divisor search, up to five
// cuts by ten, the two products and the wait on the divider.
// One word is in work at a time; the next request is taken the cycle after the result
// word is loaded. Reset (synchronous) clears the register, all channel state and both
// handshakes.
module vsync_field_duration_updater #(
   parameter int NUM_CHANNELS = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vfdu_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vfdu_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_data
);

   // How the period is found. The 90 kHz count and the residual are first reduced by
   // their common divisor; since 90000 = 2^4 * 3^2 * 5^4, that divisor is found by trial
   // division of the residual by 2, 3 and 5, each done as a multiplication by a
   // reciprocal on the shared multiplier, and the remaining tick count comes from the
   // exponents that were taken out. Then the tick count, divider and residual are cut
   // by ten while the divider, times the reduced tick count as it stood before any cut,
   // overflows a word. The product of the cut tick count and divider is then divided by
   // the residual in the iterative divider, or the period saturates if the residual was cut to zero.

   localparam int W      = vfdu_pkg::WORD_W;
   localparam int CW     = vfdu_pkg::CLK_W;
   localparam int CHIDXW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_GMUL  = 4'd2;
   localparam logic [3:0] S_GTEST = 4'd3;
   localparam logic [3:0] S_SMUL  = 4'd4;
   localparam logic [3:0] S_SCHK  = 4'd5;
   localparam logic [3:0] S_SDIV  = 4'd6;
   localparam logic [3:0] S_DWAIT = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;
   localparam logic [3:0] S_PMUL  = 4'd10;
   localparam logic [3:0] S_PCHK  = 4'd11;

   // Trial primes.
   localparam logic [1:0] P_2 = 2'd0;
   localparam logic [1:0] P_3 = 2'd1;
   localparam logic [1:0] P_5 = 2'd2;

   function automatic logic [W-1:0] prime_recip(input logic [1:0] p);
      case (p)
         P_2:     prime_recip = vfdu_pkg::RECIP_2;
         P_3:     prime_recip = vfdu_pkg::RECIP_3;
         P_5:     prime_recip = vfdu_pkg::RECIP_5;
         default: prime_recip = vfdu_pkg::RECIP_2;
      endcase
   endfunction

   function automatic logic [W-1:0] prime_quot(input logic [2*W-1:0] m, input logic [1:0] p);
      case (p)
         P_2:     prime_quot = W'(m >> vfdu_pkg::SHIFT_2);
         P_3:     prime_quot = W'(m >> vfdu_pkg::SHIFT_3);
         P_5:     prime_quot = W'(m >> vfdu_pkg::SHIFT_5);
         default: prime_quot = W'(m >> vfdu_pkg::SHIFT_2);
      endcase
   endfunction

   // q times the prime, by shift and add.
   function automatic logic [W+1:0] prime_times(input logic [W-1:0] q, input logic [1:0] p);
      case (p)
         P_2:     prime_times = {1'b0, q, 1'b0};
         P_3:     prime_times = {1'b0, q, 1'b0} + {2'b00, q};
         P_5:     prime_times = {q, 2'b00} + {2'b00, q};
         default: prime_times = {1'b0, q, 1'b0};
      endcase
   endfunction

   // 90000 divided by 2^e2 * 3^e3 * 5^e5, with e2 and e5 up to 4 and e3 up to 2.
   function automatic logic [CW-1:0] ticks_left(input logic [2:0] e2, input logic [1:0] e3,
                                                input logic [2:0] e5);
      logic [CW-1:0] f2;
      logic [CW-1:0] f3;
      logic [CW-1:0] f5;
      f2 = CW'(5'd16 >> e2);
      case (e3)
         2'd0:    f3 = CW'(9);
         2'd1:    f3 = CW'(3);
         default: f3 = CW'(1);
      endcase
      case (e5)
         3'd0:    f5 = CW'(625);
         3'd1:    f5 = CW'(125);
         3'd2:    f5 = CW'(25);
         3'd3:    f5 = CW'(5);
         default: f5 = CW'(1);
      endcase
      ticks_left = CW'(f2 * f3 * f5);
   endfunction

   // Configuration register.
   logic [1:0] mask_ff;

   // Per-channel rate state.
   logic [W-1:0] sres_ff   [NUM_CHANNELS];
   logic [W-1:0] sdiv_ff   [NUM_CHANNELS];
   logic         sil_ff    [NUM_CHANNELS];
   logic [W-1:0] sframe_ff [NUM_CHANNELS];
   logic [W-1:0] sfield_ff [NUM_CHANNELS];

   // Sequencer and working registers.
   logic [3:0]        state_ff;
   logic [3:0]        state_in;
   vfdu_pkg::req_type req_ff;
   vfdu_pkg::rsp_type result_ff;
   logic [1:0]        prime_ff;
   logic [2:0]        e2_ff;
   logic [1:0]        e3_ff;
   logic [2:0]        e5_ff;
   logic [1:0]        sub_ff;
   logic [W-1:0]      rs_ff;
   logic [W-1:0]      dt_ff;
   logic [CW-1:0]     clk_ff;
   logic [CW-1:0]     clk0_ff;
   logic [W-1:0]      frame_ff;
   logic [2*W-1:0]    mul_ff;
   logic              rsp_valid_ff;
   vfdu_pkg::rsp_type rsp_word_ff;

   // The shared multiplier.
   logic [W-1:0] mul_a;
   logic [W-1:0] mul_b;

   logic         div_start;
   logic         div_done;
   logic [W-1:0] div_quo;

   logic              ch_ok;
   logic [CHIDXW-1:0] ch_idx;
   logic              fixed;
   logic              zero_rate;
   logic              same_rate;
   logic [W-1:0]      gq;
   logic              take;
   logic              too_big;
   logic              rsp_free;

   logic [W-1:0] field_c;
   logic         short_c;
   logic [W-1:0] frame_n;
   logic [W-1:0] field_n;
   logic [W-1:0] div_n;
   logic         changed;

   assign ch_ok  = (int'(req_ff.channel) < NUM_CHANNELS);
   assign ch_idx = ch_ok ? req_ff.channel[CHIDXW-1:0] : '0;
   // Only channels 0 and 1 have a bit in the fixed-rate mask.
   assign fixed     = !req_ff.channel[1] && mask_ff[req_ff.channel[0]];
   assign zero_rate = (req_ff.rate_residual == '0) || (req_ff.rate_divider == '0);
   assign same_rate = (sres_ff[ch_idx] == req_ff.rate_residual) &&
                      (sdiv_ff[ch_idx] == req_ff.rate_divider) &&
                      (sil_ff[ch_idx] == req_ff.interlaced);

   // Trial division: the prime is taken out while it divides the residual exactly and
   // 90000 still holds that factor.
   assign gq   = prime_quot(mul_ff, prime_ff);
   assign take = (prime_times(gq, prime_ff) == {2'b00, rs_ff}) &&
                 (((prime_ff == P_2) && (e2_ff != 3'd4)) ||
                  ((prime_ff == P_3) && (e3_ff != 2'd2)) ||
                  ((prime_ff == P_5) && (e5_ff != 3'd4)));

   // The divider times the reduced tick count before any cut does not fit a word, and the
   // cut tick count has not yet reached zero.
   assign too_big = (clk_ff != '0) && (mul_ff[2*W-1:W] != '0);

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Interlaced fields are half a frame; short fields are doubled with the divider.
   assign field_c = req_ff.interlaced ? (frame_ff >> 1) : frame_ff;
   assign short_c = (field_c < vfdu_pkg::MIN_FIELD);
   assign frame_n = short_c ? {frame_ff[W-2:0], 1'b0} : frame_ff;
   assign field_n = short_c ? {field_c[W-2:0], 1'b0} : field_c;
   assign div_n   = short_c ? {req_ff.rate_divider[W-2:0], 1'b0} : req_ff.rate_divider;
   assign changed = (sfield_ff[ch_idx] != field_n);

   always_comb begin
      state_in  = state_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (ch_ok && !fixed && !zero_rate && !req_ff.destination[1] && !same_rate) begin
               state_in = S_GMUL;
            end else begin
               state_in = S_OUT;
            end
         end
         S_GMUL: begin
            mul_a    = rs_ff;
            mul_b    = prime_recip(prime_ff);
            state_in = S_GTEST;
         end
         S_GTEST: begin
            if (take || (prime_ff != P_5)) begin
               state_in = S_GMUL;
            end else begin
               state_in = S_SMUL;
            end
         end
         S_SMUL: begin
            mul_a    = dt_ff;
            mul_b    = W'(clk0_ff);
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (too_big) begin
               state_in = S_SDIV;
            end else begin
               state_in = S_PMUL;
            end
         end
         S_SDIV: begin
            // One operand a cycle goes through the divide-by-ten reciprocal.
            mul_b = vfdu_pkg::RECIP_10;
            case (sub_ff)
               2'd0:    mul_a = dt_ff;
               2'd1:    mul_a = W'(clk_ff);
               2'd2:    mul_a = rs_ff;
               default: mul_a = '0;
            endcase
            if (sub_ff == 2'd3) state_in = S_SMUL;
         end
         S_PMUL: begin
            // The dividend: cut tick count times cut divider, which always fits a word.
            mul_a    = dt_ff;
            mul_b    = W'(clk_ff);
            state_in = S_PCHK;
         end
         S_PCHK: begin
            if (rs_ff == '0) begin
               state_in = S_FIN;
            end else begin
               div_start = 1'b1;
               state_in  = S_DWAIT;
            end
         end
         S_DWAIT: begin
            if (div_done) state_in = S_FIN;
         end
         S_FIN: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   // Working registers of the sequencer.
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_valid) req_ff <= req_word;
         end
         S_CHECK: begin
            rs_ff    <= req_ff.rate_residual;
            prime_ff <= P_2;
            e2_ff    <= '0;
            e3_ff    <= '0;
            e5_ff    <= '0;
            if (!ch_ok) begin
               result_ff.frame_period <= '0;
               result_ff.field_period <= '0;
            end else begin
               result_ff.frame_period <= sframe_ff[ch_idx];
               result_ff.field_period <= sfield_ff[ch_idx];
            end
            if (!ch_ok) begin
               result_ff.status <= vfdu_pkg::ST_BAD_CHAN;
            end else if (fixed) begin
               result_ff.status <= vfdu_pkg::ST_FIXED;
            end else if (zero_rate) begin
               result_ff.status <= vfdu_pkg::ST_ZERO_RATE;
            end else if (req_ff.destination[1]) begin
               result_ff.status <= vfdu_pkg::ST_BAD_DEST;
            end else begin
               result_ff.status <= vfdu_pkg::ST_UNCHANGED;
            end
         end
         S_GTEST: begin
            if (take) begin
               rs_ff <= gq;
               case (prime_ff)
                  P_2:     e2_ff <= e2_ff + 1'b1;
                  P_3:     e3_ff <= e3_ff + 1'b1;
                  default: e5_ff <= e5_ff + 1'b1;
               endcase
            end else if (prime_ff == P_5) begin
               clk_ff  <= ticks_left(e2_ff, e3_ff, e5_ff);
               clk0_ff <= ticks_left(e2_ff, e3_ff, e5_ff);
               dt_ff   <= req_ff.rate_divider;
            end else begin
               prime_ff <= prime_ff + 1'b1;
            end
         end
         S_SCHK: begin
            sub_ff <= '0;
         end
         S_SDIV: begin
            sub_ff <= sub_ff + 1'b1;
            case (sub_ff)
               2'd1:    dt_ff  <= W'(mul_ff >> vfdu_pkg::SHIFT_10);
               2'd2:    clk_ff <= CW'(mul_ff >> vfdu_pkg::SHIFT_10);
               2'd3:    rs_ff  <= W'(mul_ff >> vfdu_pkg::SHIFT_10);
               default: dt_ff  <= dt_ff;
            endcase
         end
         S_PCHK: begin
            // A residual scaled down to nothing saturates the period.
            if (rs_ff == '0) frame_ff <= vfdu_pkg::PERIOD_MAX;
         end
         S_DWAIT: begin
            if (div_done) frame_ff <= div_quo;
         end
         S_FIN: begin
            if (changed) begin
               result_ff.status       <= vfdu_pkg::ST_UPDATED;
               result_ff.frame_period <= frame_n;
               result_ff.field_period <= field_n;
            end else begin
               result_ff.status       <= vfdu_pkg::ST_UNCHANGED;
               result_ff.frame_period <= sframe_ff[ch_idx];
               result_ff.field_period <= sfield_ff[ch_idx];
            end
         end
         default: begin
            rs_ff <= rs_ff;
         end
      endcase
   end

   // Channel state and the configuration register. The rate is always stored once the
   // period has been worked out; the periods only when the field period moves.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            sres_ff[i]   <= '0;
            sdiv_ff[i]   <= W'(1);
            sil_ff[i]    <= 1'b1;
            sframe_ff[i] <= vfdu_pkg::PERIOD_RESET;
            sfield_ff[i] <= vfdu_pkg::PERIOD_RESET;
         end
      end else begin
         if (csr_valid) mask_ff <= csr_data;
         if (state_ff == S_FIN) begin
            sres_ff[ch_idx] <= req_ff.rate_residual;
            sdiv_ff[ch_idx] <= div_n;
            sil_ff[ch_idx]  <= req_ff.interlaced;
            if (changed) begin
               sframe_ff[ch_idx] <= frame_n;
               sfield_ff[ch_idx] <= field_n;
            end
         end
      end
   end

   // Output register: a finished word may wait here while the next request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_OUT) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_OUT) && rsp_free) rsp_word_ff <= result_ff;
   end

   vfdu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_ff[W-1:0]),
      .divisor  (rs_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign csr_ready = 1'b1;

endmodule

// ===== sv/vfdu_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on vfdu_pkg for the word width.
module vfdu_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [vfdu_pkg::WORD_W-1:0] dividend,
   input  logic [vfdu_pkg::WORD_W-1:0] divisor,
   output logic                       done,
   output logic [vfdu_pkg::WORD_W-1:0] quotient
);

   localparam int W    = vfdu_pkg::WORD_W;
   localparam int CNTW = $clog2(W);

   logic            busy_ff;
   logic            done_ff;
   logic [CNTW-1:0] cnt_ff;
   logic [W-1:0]    rem_ff;
   logic [W-1:0]    quo_ff;
   logic [W-1:0]    dsr_ff;

   logic [W:0] rem_sh;
   logic       fits;

   assign rem_sh = {rem_ff, quo_ff[W-1]};
   assign fits   = (rem_sh >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         // The partial remainder always stays below the divisor, so W bits hold it.
         rem_ff <= fits ? W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[W-1:0];
         quo_ff <= {quo_ff[W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
